@@ hdl/skx_pkg.sv @@
// ----------------------------------------------------------------------------
// skx_pkg
// Types, constants and mixing functions for the twelve-word subkey expander.
// ----------------------------------------------------------------------------
`default_nettype none
package skx_pkg;

  typedef logic [31:0] word_t;
  typedef logic [5:0][31:0] six_t;  // [0]=a ... [5]=f
  typedef logic [3:0] idx_t;

  localparam int SUBKEYS = 12;
  localparam idx_t LAST_IDX = idx_t'(SUBKEYS - 1);
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 40;

  localparam int NPAIRS = 16;
  localparam logic [4:0] SWAP_P [NPAIRS] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7,
    5'd8, 5'd10, 5'd11, 5'd12, 5'd13, 5'd15, 5'd17, 5'd22
  };
  localparam logic [4:0] SWAP_Q [NPAIRS] = '{
    5'd9, 5'd18, 5'd27, 5'd20, 5'd19, 5'd28, 5'd21, 5'd14,
    5'd23, 5'd24, 5'd25, 5'd30, 5'd31, 5'd16, 5'd29, 5'd26
  };

  localparam word_t M_HI3 = 32'hF000_0000;
  localparam word_t M_HI2 = 32'h00F0_0000;
  localparam word_t M_HI1 = 32'h0000_F000;
  localparam word_t M_HI0 = 32'h0000_00F0;
  localparam word_t M_LO3 = 32'h0F00_0000;
  localparam word_t M_LO2 = 32'h000F_0000;
  localparam word_t M_LO1 = 32'h0000_0F00;
  localparam word_t M_LO0 = 32'h0000_000F;

  function automatic word_t rol(input word_t x, input int n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  // pairs are disjoint, so every swap is independent
  function automatic word_t permute(input word_t w);
    word_t p;
    p = w;
    for (int i = 0; i < NPAIRS; i++) begin
      p[SWAP_P[i]] = w[SWAP_Q[i]];
      p[SWAP_Q[i]] = w[SWAP_P[i]];
    end
    permute = p;
  endfunction

  function automatic six_t split(input word_t key);
    word_t p, up, down, left, right;
    six_t s;
    p = permute(key);
    up = {16'h0, p[31:16]};
    down = {16'h0, p[15:0]};
    left = (p & M_HI3) | ((p & M_HI2) << 4) | ((p & M_HI1) << 8) | ((p & M_HI0) << 12);
    // lowest nibble of the right gather lands on bits 14..17
    right = ((p & M_LO3) << 4) | ((p & M_LO2) << 8) | ((p & M_LO1) << 12)
          | ((p & M_LO0) << 14);
    s[0] = up ^ down;
    s[1] = left ^ right;
    s[2] = up ^ left;
    s[3] = down ^ right;
    s[4] = up ^ right;
    s[5] = down ^ left;
    split = s;
  endfunction

  function automatic six_t mix_round(input six_t s);
    word_t a0, b0, c0, d0, e0, f0, a, b, c, d, e, f;
    six_t r;
    a0 = s[0]; b0 = s[1]; c0 = s[2]; d0 = s[3]; e0 = s[4]; f0 = s[5];
    a0 = a0 ^ (~b0 & c0);
    d0 = d0 ^ (~e0 & f0);
    b0 = b0 ^ (~c0 & d0);
    e0 = e0 ^ (~f0 & a0);
    c0 = c0 ^ (~d0 & e0);
    f0 = f0 ^ (~a0 & b0);
    a = rol(a0, 5);
    b = rol(b0, 11);
    c = rol(c0, 17);
    d = rol(d0, 25);
    e = rol(e0, 19);
    f = rol(f0, 13);
    a = a + (b << 1);
    b = b + a;
    c = c + (d << 1);
    d = d + c;
    e = e + (f << 1);
    f = f + e;
    r[0] = a; r[1] = b; r[2] = c; r[3] = d; r[4] = e; r[5] = f;
    mix_round = r;
  endfunction

  function automatic word_t subkey(input six_t s, input idx_t i);
    case (i)
      4'd0:    subkey = s[0];
      4'd1:    subkey = s[1];
      4'd2:    subkey = s[2];
      4'd3:    subkey = s[3];
      4'd4:    subkey = s[4];
      4'd5:    subkey = s[5];
      4'd6:    subkey = s[0] ^ s[2];
      4'd7:    subkey = s[1] ^ s[3];
      4'd8:    subkey = s[2] ^ s[4];
      4'd9:    subkey = s[3] ^ s[5];
      4'd10:   subkey = s[4] ^ s[0];
      4'd11:   subkey = s[5] ^ s[1];
      default: subkey = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/skx_split.sv @@
// ----------------------------------------------------------------------------
// skx_split
// Input stage: bit permutation, half and nibble split, XOR into six words.
// ----------------------------------------------------------------------------
`default_nettype none
module skx_split (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire skx_pkg::word_t in_key,
  input  wire logic          in_fin,
  output logic               out_valid,
  input  wire logic          out_ready,
  output skx_pkg::six_t      out_data,
  output logic               out_fin
);

  logic valid_r;
  skx_pkg::six_t data_r;
  logic fin_r;

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready) begin
      data_r <= skx_pkg::split(in_key);
      fin_r <= in_fin;
    end
  end

  assign out_valid = valid_r;
  assign out_data = data_r;
  assign out_fin = fin_r;

endmodule
`default_nettype wire

@@ hdl/skx_round.sv @@
// ----------------------------------------------------------------------------
// skx_round
// One registered mixing round: chi layer, rotations, pseudo-Hadamard adds.
// ----------------------------------------------------------------------------
`default_nettype none
module skx_round (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire skx_pkg::six_t in_data,
  input  wire logic          in_fin,
  output logic               out_valid,
  input  wire logic          out_ready,
  output skx_pkg::six_t      out_data,
  output logic               out_fin
);

  logic valid_r;
  skx_pkg::six_t data_r;
  logic fin_r;

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready) begin
      data_r <= skx_pkg::mix_round(in_data);
      fin_r <= in_fin;
    end
  end

  assign out_valid = valid_r;
  assign out_data = data_r;
  assign out_fin = fin_r;

endmodule
`default_nettype wire

@@ hdl/skx_serial.sv @@
// ----------------------------------------------------------------------------
// skx_serial
// Output serializer: holds six mixed words, emits twelve subkeys in order.
// ----------------------------------------------------------------------------
`default_nettype none
module skx_serial (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load_valid,
  output logic               load_ready,
  input  wire skx_pkg::six_t load_data,
  input  wire logic          load_fin,
  output logic               out_valid,
  input  wire logic          out_ready,
  output skx_pkg::word_t     out_word,
  output skx_pkg::idx_t      out_idx,
  output logic               out_last,
  output logic               out_last_key
);

  logic busy_r;
  skx_pkg::idx_t idx_r;
  skx_pkg::six_t words_r;
  logic fin_r;
  logic at_last;

  assign at_last = (idx_r == skx_pkg::LAST_IDX);
  assign load_ready = !busy_r || (out_ready && at_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
    end else if (load_ready && load_valid) begin
      busy_r <= 1'b1;
      idx_r <= '0;
    end else if (busy_r && out_ready) begin
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 4'd1;
      end
    end
    if (load_ready && load_valid) begin
      words_r <= load_data;
      fin_r <= load_fin;
    end
  end

  assign out_valid = busy_r;
  assign out_word = skx_pkg::subkey(words_r, idx_r);
  assign out_idx = idx_r;
  assign out_last = busy_r && at_last;
  assign out_last_key = busy_r && at_last && fin_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= skx_pkg::LAST_IDX)
    else $error("subkey index beyond last");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_ready |=> busy_r && $stable(idx_r))
    else $error("subkey index moved during stall");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_ready && !at_last |=> idx_r == $past(idx_r) + 4'd1)
    else $error("subkey skipped");
  a_key_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_key |-> out_last && out_valid)
    else $error("key end off the last subkey");

endmodule
`default_nettype wire

@@ hdl/subkey_expand_twelve_words.sv @@
// Key word accept to first subkey: split, per-round and serializer registers.
// Throughput: one subkey per cycle while out_tready is high, from the output
//   serializer; the split and round stages buffer further key words meanwhile.
// Reset: synchronous active-low rst_n clears all stage valid bits and the
//   serializer; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
// subkey_expand_twelve_words
// Expands one 32-bit key word into twelve 32-bit subkeys.
// ----------------------------------------------------------------------------
`default_nettype none
module subkey_expand_twelve_words #(
  parameter int MIX_ROUNDS = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [skx_pkg::IN_TDATA_W-1:0]    in_tdata,  // [31:0] key_word
  input  wire logic                              in_tlast,  // final_word
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [skx_pkg::OUT_TDATA_W-1:0]        out_tdata, // [31:0] subkey_word,
                                                            // [35:32] subkey_index
  output logic                                   out_tlast, // last_of_run
  output logic                                   out_tuser  // last_of_key
);

  logic [MIX_ROUNDS:0] st_valid;
  logic [MIX_ROUNDS:0] st_ready;
  logic [MIX_ROUNDS:0] st_fin;
  skx_pkg::six_t st_data [MIX_ROUNDS+1];

  skx_pkg::word_t sub_word;
  skx_pkg::idx_t sub_idx;

  skx_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_key    (in_tdata[31:0]),
    .in_fin    (in_tlast),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_data  (st_data[0]),
    .out_fin   (st_fin[0])
  );

  for (genvar r = 0; r < MIX_ROUNDS; r++) begin : g_round
    skx_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[r]),
      .in_ready  (st_ready[r]),
      .in_data   (st_data[r]),
      .in_fin    (st_fin[r]),
      .out_valid (st_valid[r+1]),
      .out_ready (st_ready[r+1]),
      .out_data  (st_data[r+1]),
      .out_fin   (st_fin[r+1])
    );
  end

  skx_serial u_serial (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_valid   (st_valid[MIX_ROUNDS]),
    .load_ready   (st_ready[MIX_ROUNDS]),
    .load_data    (st_data[MIX_ROUNDS]),
    .load_fin     (st_fin[MIX_ROUNDS]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_word     (sub_word),
    .out_idx      (sub_idx),
    .out_last     (out_tlast),
    .out_last_key (out_tuser)
  );

  assign out_tdata = {4'b0000, sub_idx, sub_word};

endmodule
`default_nettype wire

@@ tb/sv/subkey_expand_twelve_words_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subkey_expand_twelve_words_check
// Watches the key and subkey streams and predicts the twelve subkeys of every
// accepted key word. Each subkey word leaving the block is compared field by
// field with the oldest prediction; failures are counted for the bench top.
// ----------------------------------------------------------------------------
module subkey_expand_twelve_words_check #(
  parameter int ROUNDS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key_word
  input  logic        in_tlast,   // final_word
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] subkey_word, [35:32] subkey_index
  input  logic        out_tlast,  // last_of_run
  input  logic        out_tuser,  // last_of_key
  output int          fail_count,
  output int          waiting
);

  typedef struct packed {
    skx_pkg::word_t value;
    skx_pkg::idx_t  pos;
    logic           run_end;
    logic           key_end;
  } subkey_t;

  typedef logic [11:0][31:0] subkey_set_t;

  localparam int PAIR_LO [16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 11, 12, 13, 15, 17, 22};
  localparam int PAIR_HI [16] = '{9, 18, 27, 20, 19, 28, 21, 14, 23, 24, 25, 30, 31, 16, 29, 26};

  subkey_t subkey_q[$];
  int errs = 0;
  int pending_n = 0;

  assign fail_count = errs;
  assign waiting = pending_n;

  function automatic skx_pkg::word_t rotl(input skx_pkg::word_t x, input int n);
    logic [63:0] wide;
    wide = {x, x} << n;
    return wide[63:32];
  endfunction

  function automatic subkey_set_t expand_key(input skx_pkg::word_t key);
    skx_pkg::word_t p, up, down, left, right;
    skx_pkg::word_t a, b, c, d, e, f;
    skx_pkg::word_t a0, b0, c0, d0, e0, f0;
    subkey_set_t ks;
    p = key;
    for (int i = 0; i < 16; i++) begin
      p[PAIR_LO[i]] = key[PAIR_HI[i]];
      p[PAIR_HI[i]] = key[PAIR_LO[i]];
    end
    up = {16'h0, p[31:16]};
    down = {16'h0, p[15:0]};
    left = {p[31:28], p[23:20], p[15:12], p[7:4], 16'h0};
    // low gather: top three nibbles packed from bit 20 up, the last one at 14
    right = {p[27:24], p[19:16], p[11:8], 20'h0} | ({28'h0, p[3:0]} << 14);
    a = up ^ down;
    b = left ^ right;
    c = up ^ left;
    d = down ^ right;
    e = up ^ right;
    f = down ^ left;
    for (int r = 0; r < ROUNDS; r++) begin
      a0 = a ^ (~b & c);
      d0 = d ^ (~e & f);
      b0 = b ^ (~c & d0);
      e0 = e ^ (~f & a0);
      c0 = c ^ (~d0 & e0);
      f0 = f ^ (~a0 & b0);
      a = rotl(a0, 5);
      b = rotl(b0, 11);
      c = rotl(c0, 17);
      d = rotl(d0, 32 - 7);
      e = rotl(e0, 32 - 13);
      f = rotl(f0, 32 - 19);
      a = a + (b << 1);
      b = b + a;
      c = c + (d << 1);
      d = d + c;
      e = e + (f << 1);
      f = f + e;
    end
    ks[0] = a;
    ks[1] = b;
    ks[2] = c;
    ks[3] = d;
    ks[4] = e;
    ks[5] = f;
    ks[6] = a ^ c;
    ks[7] = b ^ d;
    ks[8] = c ^ e;
    ks[9] = d ^ f;
    ks[10] = e ^ a;
    ks[11] = f ^ b;
    return ks;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    errs++;
  endtask

  always @(posedge clk) begin
    subkey_set_t ks;
    subkey_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        ks = expand_key(in_tdata);
        for (int i = 0; i < skx_pkg::SUBKEYS; i++) begin
          want.value = ks[i];
          want.pos = skx_pkg::idx_t'(i);
          want.run_end = (i == skx_pkg::SUBKEYS - 1);
          want.key_end = (i == skx_pkg::SUBKEYS - 1) && in_tlast;
          subkey_q.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        if (subkey_q.size() == 0) begin
          $display("%0t: unexpected subkey word %h", $time, out_tdata);
          errs++;
        end else begin
          want = subkey_q.pop_front();
          if (out_tdata[31:0] !== want.value)
            flag_mismatch("subkey_word", want.value, out_tdata[31:0]);
          if (out_tdata[35:32] !== want.pos)
            flag_mismatch("subkey_index", 32'(want.pos), 32'(out_tdata[35:32]));
          if (out_tlast !== want.run_end)
            flag_mismatch("last_of_run", 32'(want.run_end), 32'(out_tlast));
          if (out_tuser !== want.key_end)
            flag_mismatch("last_of_key", 32'(want.key_end), 32'(out_tuser));
        end
      end
    end
    pending_n <= subkey_q.size();
  end

endmodule

@@ tb/sv/subkey_expand_twelve_words_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subkey_expand_twelve_words_test
// Drives key words into the subkey expander: a directed set of edge values,
// a long output hold that backs up the input, then random key words with
// random gaps on both streams and a gap-free tail. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module subkey_expand_twelve_words_test;

  localparam int ROUNDS = 2;
  localparam int LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  int   fail_count;
  int   waiting;
  int   cycles = 0;
  logic word_taken = 1'b0;
  bit   tx_gaps = 1'b1;
  bit   rx_gaps = 1'b1;
  bit   rx_hold_req = 1'b0;

  always #5 clk = ~clk;

  subkey_expand_twelve_words #(.MIX_ROUNDS(ROUNDS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  subkey_expand_twelve_words_check #(.ROUNDS(ROUNDS)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .fail_count(fail_count), .waiting(waiting)
  );

  always @(posedge clk) begin
    word_taken <= in_tvalid && in_tready;
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // subkey receiver
  initial begin
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_word(input skx_pkg::word_t key, input logic fin);
    in_tdata <= key;
    in_tlast <= fin;
    in_tvalid <= 1'b1;
    do @(negedge clk); while (!word_taken);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= $urandom;
      in_tlast <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, bit patterns, final marker on the same key
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(32'h0000_FFFF, 1'b0);
    send_word(32'hFFFF_0000, 1'b1);
    send_word(32'h0F0F_0F0F, 1'b0);
    send_word(32'hF0F0_F0F0, 1'b0);
    send_word(32'h0000_000F, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h0040_0200, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h1234_5678, 1'b1);
    send_word(32'hDEAD_BEEF, 1'b0);
    send_word(32'h7FFF_FFFE, 1'b1);

    // long output hold: input must back up and stall
    rx_hold_req = 1'b1;
    tx_gaps = 1'b0;
    repeat (16) send_word($urandom, 1'($urandom_range(0, 1)));
    tx_gaps = 1'b1;

    // drain completely before continuing
    in_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);

    repeat (170) send_word($urandom, $urandom_range(0, 3) == 0);

    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (30) send_word($urandom, $urandom_range(0, 3) == 0);

    in_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4 * ROUNDS + 16) @(negedge clk);

    if (fail_count == 0 && waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
